### sv/bss_pkg.sv
`default_nettype none

package bss_pkg;

    // Largest group the schedule supports.
    localparam int MAX_RANKS = 1024;

    // Field widths.
    localparam int RANK_W  = 10;
    localparam int SIZE_W  = 11;
    localparam int BYTES_W = 31;
    localparam int CFG_W   = 11;

    // Divider runs one quotient bit per cycle over the padded byte count.
    localparam int DIV_W   = BYTES_W + 1;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // Wide enough for a piece times a relative rank or a mask.
    localparam int PROD_W  = BYTES_W + SIZE_W;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_GROUP_SIZE = 1'b0,
        REG_MY_RANK    = 1'b1
    } bss_reg_idx_t;

    // Operation kinds.
    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_RECV = 2'd1,
        OP_SEND = 2'd2,
        OP_BAD  = 2'd3
    } bss_op_kind_t;

    // One request beat.
    typedef struct packed {
        logic [RANK_W-1:0]  root_rank;
        logic [BYTES_W-1:0] total_bytes;
    } bss_req_t;

    // One operation beat.
    typedef struct packed {
        bss_op_kind_t       op_kind;
        logic [RANK_W-1:0]  peer_rank;
        logic [BYTES_W-1:0] byte_offset;
        logic [BYTES_W-1:0] byte_count;
        logic               last_op;
    } bss_op_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_MULT,
        ST_PARENT,
        ST_SEND,
        ST_FINISH
    } bss_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic div_step;
        logic mul;
        logic par_step;
        logic snd_step;
        logic fin;
    } bss_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic bad;
        logic div_last;
        logic par_stop;
        logic snd_stop;
        logic can_step;
        logic out_free;
    } bss_stat_t;

endpackage

`default_nettype wire

### sv/binomial_scatter_schedule_unit.sv
// Channel   Direction  Handshake          Beat
// req       in         req_valid/stall    root_rank, total_bytes
// op        out        op_valid/stall     op_kind, peer_rank, byte_offset, byte_count, last_op
// cfg       in         cfg_we             cfg_index, cfg_data (group_size, my_rank)
//
// A request is accepted, then run through the serial divider, the piece times relative rank product,
// the parent search, which tries one mask bit at a time, and the send walk, which tries one child
// mask at a time before it is left; last the final beat is loaded.
// A bad argument goes straight to the final beat. One request is worked at a time; its final
// beat waits in the output register while the next one is accepted.
// Reset is asynchronous. A stall on op holds the walk once pending and output are full.
`default_nettype none

module binomial_scatter_schedule_unit (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [0:0]                 cfg_index,
    input  wire logic [bss_pkg::CFG_W-1:0]  cfg_data,
    input  wire logic                       req_valid,
    output logic                            req_stall,
    input  wire bss_pkg::bss_req_t          req,
    output logic                            op_valid,
    input  wire logic                       op_stall,
    output bss_pkg::bss_op_t                op
);

    bss_pkg::bss_cmd_t  cmd;
    bss_pkg::bss_stat_t stat;

    // Sequencing of the divide, parent search and send walk.
    bss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Arithmetic, configuration and output registers.
    bss_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .op_valid  (op_valid),
        .op_stall  (op_stall),
        .op        (op)
    );

endmodule

`default_nettype wire

### sv/bss_ctrl.sv
`default_nettype none

module bss_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire bss_pkg::bss_stat_t stat,
    output bss_pkg::bss_cmd_t       cmd
);

    bss_pkg::bss_state_t state_reg;
    bss_pkg::bss_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bss_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        unique case (state_reg)
            bss_pkg::ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.bad ? bss_pkg::ST_FINISH : bss_pkg::ST_DIVIDE;
                end
            end
            bss_pkg::ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = bss_pkg::ST_MULT;
                end
            end
            bss_pkg::ST_MULT:
            begin
                cmd.mul    = 1'b1;
                state_next = bss_pkg::ST_PARENT;
            end
            bss_pkg::ST_PARENT:
            begin
                if (stat.can_step)
                begin
                    cmd.par_step = 1'b1;
                    if (stat.par_stop)
                    begin
                        state_next = bss_pkg::ST_SEND;
                    end
                end
            end
            bss_pkg::ST_SEND:
            begin
                if (stat.snd_stop)
                begin
                    state_next = bss_pkg::ST_FINISH;
                end
                else if (stat.can_step)
                begin
                    cmd.snd_step = 1'b1;
                end
            end
            bss_pkg::ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.fin    = 1'b1;
                    state_next = bss_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bss_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/bss_datapath.sv
`default_nettype none

module bss_datapath (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [0:0]                  cfg_index,
    input  wire logic [bss_pkg::CFG_W-1:0]   cfg_data,
    input  wire bss_pkg::bss_req_t           req,
    input  wire bss_pkg::bss_cmd_t           cmd,
    output bss_pkg::bss_stat_t               stat,
    output logic                             op_valid,
    input  wire logic                        op_stall,
    output bss_pkg::bss_op_t                 op
);

    localparam int RW = bss_pkg::RANK_W;
    localparam int SW = bss_pkg::SIZE_W;
    localparam int BW = bss_pkg::BYTES_W;
    localparam int DW = bss_pkg::DIV_W;
    localparam int PW = bss_pkg::PROD_W;
    localparam int MW = SW + 1;

    // Configuration registers.
    logic [SW-1:0]  size_reg;
    logic [RW-1:0]  rank_reg;

    // Per-request working registers.
    logic                            bad_reg;
    logic [BW-1:0]                   nbytes_reg;
    logic [SW-1:0]                   rel_reg;
    logic [DW-1:0]                   dvd_reg;
    logic [SW-1:0]                   rem_reg;
    logic [bss_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic [PW-1:0]                   prod_reg;
    logic [BW-1:0]                   curr_reg;
    logic [3:0]                      k_reg;

    // Pending operation and output register.
    bss_pkg::bss_op_t  pend_reg;
    logic              pend_valid_reg;
    bss_pkg::bss_op_t  out_reg;
    logic              out_valid_reg;

    logic            bad_now;
    logic [SW:0]     rel_sum;
    logic [SW:0]     div_trial;
    logic            div_sub;
    logic [BW-1:0]   piece;
    logic [MW-1:0]   size_ext;
    logic [MW-1:0]   rank_ext;
    logic [MW-1:0]   mask_par;
    logic            par_end;
    logic            par_hit;
    logic [MW-1:0]   src_peer;
    logic            rsz_pos;
    logic [BW-1:0]   rsz;
    logic [3:0]      k_dn;
    logic [MW-1:0]   mask_snd;
    logic            child_ok;
    logic [PW-1:0]   keep;
    logic            send_ok;
    logic [BW-1:0]   ssz;
    logic [MW-1:0]   dst_sum;
    logic [MW-1:0]   dst_peer;
    logic [PW-1:0]   snd_off;
    logic            out_free;
    logic            can_step;

    function automatic bss_pkg::bss_op_t make_op(
        input bss_pkg::bss_op_kind_t kind,
        input logic [RW-1:0]         peer,
        input logic [BW-1:0]         off,
        input logic [BW-1:0]         cnt,
        input logic                  last
    );
        bss_pkg::bss_op_t o;
        o.op_kind     = kind;
        o.peer_rank   = peer;
        o.byte_offset = off;
        o.byte_count  = cnt;
        o.last_op     = last;
        return o;
    endfunction

    // Argument check and relative rank for a new request.
    always_comb
    begin
        bad_now = (size_reg == '0)
               || ({{(32-SW){1'b0}}, size_reg} > 32'(bss_pkg::MAX_RANKS))
               || ({1'b0, req.root_rank} >= size_reg)
               || ({1'b0, rank_reg} >= size_reg);
        rel_sum = (rank_reg >= req.root_rank)
                ? {2'b00, rank_reg} - {2'b00, req.root_rank}
                : {2'b00, rank_reg} + {1'b0, size_reg} - {2'b00, req.root_rank};
    end

    // One restoring divide step per cycle.
    always_comb
    begin
        div_trial = {rem_reg, dvd_reg[DW-1]};
        div_sub   = div_trial >= {1'b0, size_reg};
        piece     = dvd_reg[BW-1:0];
    end

    // Parent search: lowest set bit of the relative rank.
    always_comb
    begin
        size_ext = {1'b0, size_reg};
        rank_ext = {2'b00, rank_reg};
        mask_par = MW'(1) << k_reg;
        par_end  = mask_par >= size_ext;
        par_hit  = (({1'b0, rel_reg}) & mask_par) != '0;
        src_peer = (rank_ext >= mask_par) ? rank_ext - mask_par
                                          : rank_ext + size_ext - mask_par;
        rsz_pos  = {{(PW-BW){1'b0}}, nbytes_reg} > prod_reg;
        rsz      = nbytes_reg - prod_reg[BW-1:0];
    end

    // Child sends, largest subtree first.
    always_comb
    begin
        k_dn     = k_reg - 4'd1;
        mask_snd = MW'(1) << k_dn;
        child_ok = ({1'b0, rel_reg} + mask_snd) < size_ext;
        keep     = {{(PW-BW){1'b0}}, piece} << k_dn;
        send_ok  = child_ok && ({{(PW-BW){1'b0}}, curr_reg} > keep);
        ssz      = curr_reg - keep[BW-1:0];
        dst_sum  = rank_ext + mask_snd;
        dst_peer = (dst_sum >= size_ext) ? dst_sum - size_ext : dst_sum;
        snd_off  = prod_reg + keep;
    end

    // Status toward the controller.
    always_comb
    begin
        out_free      = !out_valid_reg || !op_stall;
        can_step      = !pend_valid_reg || out_free;
        stat.bad      = bad_now;
        stat.div_last = cnt_reg == bss_pkg::DIV_CNT_W'(DW - 1);
        stat.par_stop = par_hit || par_end;
        stat.snd_stop = k_reg == '0;
        stat.can_step = can_step;
        stat.out_free = out_free;
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SW'(1);
            rank_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bss_pkg::REG_GROUP_SIZE: size_reg <= cfg_data[SW-1:0];
                bss_pkg::REG_MY_RANK:    rank_reg <= cfg_data[RW-1:0];
                default:                 ;
            endcase
        end
    end

    // Control flags: pending and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !op_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.load)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (cmd.par_step && par_hit && rsz_pos)
            begin
                pend_valid_reg <= 1'b1;
                if (pend_valid_reg)
                begin
                    out_valid_reg <= 1'b1;
                end
            end
            if (cmd.snd_step && send_ok)
            begin
                pend_valid_reg <= 1'b1;
                if (pend_valid_reg)
                begin
                    out_valid_reg <= 1'b1;
                end
            end
            if (cmd.fin)
            begin
                pend_valid_reg <= 1'b0;
                out_valid_reg  <= 1'b1;
            end
        end
    end

    // Working registers and operation payloads.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bad_reg    <= bad_now;
            nbytes_reg <= req.total_bytes;
            rel_reg    <= rel_sum[SW-1:0];
            curr_reg   <= (req.root_rank == rank_reg) ? req.total_bytes : '0;
            dvd_reg    <= {1'b0, req.total_bytes} + DW'(size_reg) - DW'(1);
            rem_reg    <= '0;
            cnt_reg    <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= div_sub ? SW'(div_trial - {1'b0, size_reg}) : div_trial[SW-1:0];
            dvd_reg <= {dvd_reg[DW-2:0], div_sub};
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.mul)
        begin
            prod_reg <= PW'(rel_reg) * PW'(piece);
            k_reg    <= '0;
        end
        if (cmd.par_step)
        begin
            if (par_hit)
            begin
                curr_reg <= rsz_pos ? rsz : '0;
                if (rsz_pos)
                begin
                    if (pend_valid_reg)
                    begin
                        out_reg <= pend_reg;
                    end
                    pend_reg <= make_op(bss_pkg::OP_RECV, src_peer[RW-1:0],
                                        prod_reg[BW-1:0], rsz, 1'b0);
                end
            end
            else if (!par_end)
            begin
                k_reg <= k_reg + 4'd1;
            end
        end
        if (cmd.snd_step)
        begin
            k_reg <= k_dn;
            if (send_ok)
            begin
                curr_reg <= keep[BW-1:0];
                if (pend_valid_reg)
                begin
                    out_reg <= pend_reg;
                end
                pend_reg <= make_op(bss_pkg::OP_SEND, dst_peer[RW-1:0],
                                    snd_off[BW-1:0], ssz, 1'b0);
            end
        end
        if (cmd.fin)
        begin
            if (bad_reg)
            begin
                out_reg <= make_op(bss_pkg::OP_BAD, '0, '0, '0, 1'b1);
            end
            else if (pend_valid_reg)
            begin
                out_reg         <= pend_reg;
                out_reg.last_op <= 1'b1;
            end
            else
            begin
                out_reg <= make_op(bss_pkg::OP_NONE, '0, '0, '0, 1'b1);
            end
        end
    end

    assign op_valid = out_valid_reg;
    assign op       = out_reg;

endmodule

`default_nettype wire
